@@ src/strip_position_histogrammer_core_defines.svh @@
// Assertion macros for the checker file.
`ifndef STRIP_POSITION_HISTOGRAMMER_CORE_DEFINES_SVH
`define STRIP_POSITION_HISTOGRAMMER_CORE_DEFINES_SVH

// Checked on every rising edge outside of reset.
`define SPH_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SPH_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/sph_pkg.sv @@
package sph_pkg;

  localparam int DETECTORS  = 12;
  localparam int STRIPS     = 4;
  localparam int SECTORS    = 4;
  localparam int BINS       = 1024;
  localparam int ADC_BITS   = 16;

  localparam int CHANNELS   = DETECTORS * STRIPS * SECTORS;
  localparam int PEDS       = DETECTORS * STRIPS * 2;
  localparam int CH_W       = $clog2(CHANNELS);
  localparam int PED_W      = $clog2(PEDS);
  localparam int BIN_W      = $clog2(BINS);
  localparam int HIST_DEPTH = CHANNELS * BINS;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int BIN_OUT_W  = 10;

  localparam logic [15:0] ADC_MASK = 16'((32'd1 << ADC_BITS) - 1);

  // Datapath widths.
  localparam int R4_W   = 22;
  localparam int PR_W   = 39;
  localparam int SUM_W  = 41;
  localparam int E_W    = 27;
  localparam int EN_W   = 60;
  localparam int NUM_W  = 58;
  localparam int QM_W   = 17;
  localparam int QV_W   = 19;
  localparam int DCNT_W = $clog2(QM_W);
  localparam int BP_W   = 16 + $clog2(BINS + 1);

  typedef enum logic [2:0] {
    CMD_HIT   = 3'd0,
    CMD_PED   = 3'd1,
    CMD_GAIN  = 3'd2,
    CMD_SLOPE = 3'd3,
    CMD_ICPT  = 3'd4,
    CMD_READ  = 3'd5,
    CMD_CLEAR = 3'd6,
    CMD_NOP   = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    STS_FILLED  = 3'd0,
    STS_SKIPPED = 3'd1,
    STS_UNDER   = 3'd2,
    STS_OVER    = 3'd3,
    STS_ZERO    = 3'd4,
    STS_WRITTEN = 3'd5,
    STS_READ    = 3'd6
  } sts_code_t;

  typedef enum logic [3:0] {
    S_RCLR, S_IDLE, S_DEC, S_MUL1, S_RND, S_MUL2, S_ADD, S_PREP,
    S_DIVI, S_DIV, S_FIN, S_CRD, S_CWR, S_BRD, S_CLR, S_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic tbl_wr;
    logic clr_init;
    logic clr_step;
    logic div_init;
    logic div_step;
    logic fin;
    logic bin_rd;
    logic cnt_wr;
    logic emit;
  } ctl_t;

  typedef struct packed {
    cmd_t op;
    logic ok;
    logic counted;
    logic div_last;
    logic clr_last;
  } stat_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

@@ src/sph_ctrl.sv @@
module sph_ctrl import sph_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t st,
  output ctl_t  ctl,
  output logic  busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RCLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_RCLR: if (st.clr_last) state_next = S_IDLE;
      S_IDLE: if (start) state_next = S_DEC;
      S_DEC: begin
        case (st.op)
          CMD_HIT:   state_next = st.ok ? S_MUL1 : S_DONE;
          CMD_READ:  state_next = S_BRD;
          CMD_CLEAR: state_next = S_CLR;
          default:   state_next = S_DONE;
        endcase
      end
      S_MUL1: state_next = S_RND;
      S_RND:  state_next = S_MUL2;
      S_MUL2: state_next = S_ADD;
      S_ADD:  state_next = S_PREP;
      S_PREP: state_next = S_DIVI;
      S_DIVI: state_next = S_DIV;
      S_DIV:  if (st.div_last) state_next = S_FIN;
      S_FIN:  state_next = S_CRD;
      S_CRD:  state_next = st.counted ? S_CWR : S_DONE;
      S_CWR:  state_next = S_IDLE;
      S_BRD:  state_next = S_IDLE;
      S_CLR:  if (st.clr_last) state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state)
      S_IDLE: ctl.latch = start;
      S_DEC: begin
        ctl.tbl_wr   = 1'b1;
        ctl.clr_init = 1'b1;
        ctl.bin_rd   = 1'b1;
      end
      S_DIVI: ctl.div_init = 1'b1;
      S_DIV:  ctl.div_step = 1'b1;
      S_FIN:  ctl.fin = 1'b1;
      S_RCLR, S_CLR: ctl.clr_step = 1'b1;
      S_CWR: begin
        ctl.cnt_wr = 1'b1;
        ctl.emit   = 1'b1;
      end
      S_BRD, S_DONE: ctl.emit = 1'b1;
      default: ctl = '0;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

@@ src/sph_dp.sv @@
module sph_dp import sph_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  ctl_t                  ctl,
  output stat_t                 st,
  input  logic [2:0]            command,
  input  logic [3:0]            detector,
  input  logic [1:0]            strip,
  input  logic [1:0]            sector,
  input  logic                  side,
  input  logic                  upstream,
  input  logic [15:0]           left_adc,
  input  logic [15:0]           right_adc,
  input  logic signed [31:0]    table_value,
  input  logic [10:0]           bin_index,
  output logic                  done,
  output logic [2:0]            status,
  output logic signed [15:0]    position,
  output logic [BIN_OUT_W-1:0]  bin,
  output logic [31:0]           count
);

  // Latched transaction.
  cmd_t               op;
  logic [3:0]         det;
  logic [1:0]         stp;
  logic [1:0]         sec;
  logic               sd;
  logic               upf;
  logic [15:0]        ladc;
  logic [15:0]        radc;
  logic signed [31:0] tval;
  logic [10:0]        bidx;

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      op   <= cmd_t'(command);
      det  <= detector;
      stp  <= strip;
      sec  <= sector;
      sd   <= side;
      upf  <= upstream;
      ladc <= left_adc & ADC_MASK;
      radc <= right_adc & ADC_MASK;
      tval <= table_value;
      bidx <= bin_index;
    end
  end

  logic               ok;
  logic [CH_W-1:0]    chan;
  logic [PED_W-1:0]   pbase;
  logic [HIST_AW-1:0] bin_addr;

  assign ok    = (det < DETECTORS) && (stp < STRIPS) && (sec < SECTORS);
  assign chan  = CH_W'((int'(det) * STRIPS + int'(stp)) * SECTORS + int'(sec));
  assign pbase = PED_W'((int'(det) * STRIPS + int'(stp)) * 2);
  assign bin_addr = HIST_AW'(int'(chan) * BINS + int'(bidx[BIN_W-1:0]));

  // Calibration tables.
  logic signed [19:0] ped_mem [PEDS];
  logic [15:0]        gain_mem [CHANNELS];
  logic signed [31:0] slope_mem [CHANNELS];
  logic signed [31:0] icpt_mem [CHANNELS];
  logic signed [19:0] ped_r, ped_l;
  logic [15:0]        gain_rd;
  logic signed [31:0] slope_rd, icpt_rd;

  always_ff @(posedge clk) begin
    if (ctl.tbl_wr && ok && op == CMD_PED) begin
      ped_mem[{pbase[PED_W-1:1], sd}] <= tval[19:0];
    end
    ped_r <= ped_mem[pbase];
    ped_l <= ped_mem[{pbase[PED_W-1:1], 1'b1}];
  end

  always_ff @(posedge clk) begin
    if (ctl.tbl_wr && ok && op == CMD_GAIN) begin
      gain_mem[chan] <= tval[15:0];
    end
    gain_rd <= gain_mem[chan];
  end

  always_ff @(posedge clk) begin
    if (ctl.tbl_wr && ok && op == CMD_SLOPE) begin
      slope_mem[chan] <= tval;
    end
    slope_rd <= slope_mem[chan];
  end

  always_ff @(posedge clk) begin
    if (ctl.tbl_wr && ok && op == CMD_ICPT) begin
      icpt_mem[chan] <= tval;
    end
    icpt_rd <= icpt_mem[chan];
  end

  // Energy and difference, one register stage per step.
  logic signed [R4_W-1:0]  r4, l4;
  logic signed [PR_W-1:0]  prod1;
  logic signed [SUM_W-1:0] rr, ll, esum, dsum;
  logic signed [E_W-1:0]   e4, d4;
  logic signed [EN_W-1:0]  prod2, en;
  logic signed [NUM_W-1:0] num;

  assign r4    = $signed({2'b00, radc, 4'b0000}) - R4_W'(ped_r);
  assign l4    = $signed({2'b00, ladc, 4'b0000}) - R4_W'(ped_l);
  assign prod1 = PR_W'(r4) * PR_W'($signed({1'b0, gain_rd}));
  assign esum  = (rr + ll + SUM_W'(8192)) >>> 14;
  assign dsum  = (rr - ll + SUM_W'(8192)) >>> 14;
  assign num   = NUM_W'(d4) <<< 31;

  always_ff @(posedge clk) begin
    rr    <= -SUM_W'(prod1);
    ll    <= SUM_W'(l4) <<< 14;
    e4    <= esum[E_W-1:0];
    d4    <= dsum[E_W-1:0];
    prod2 <= EN_W'(e4) * EN_W'(slope_rd);
    en    <= prod2 + (EN_W'(icpt_rd) <<< 4);
  end

  // Sign-magnitude restoring divider, one quotient bit per cycle.
  logic [NUM_W-1:0]  nmag;
  logic [EN_W-1:0]   dmag, rem;
  logic              neg, en_zero, ovf;
  logic [QM_W-1:0]   nlo, qm;
  logic [DCNT_W-1:0] dcnt;
  logic [EN_W:0]     trial;

  assign trial = {rem, nlo[QM_W-1]};

  always_ff @(posedge clk) begin
    nmag    <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    dmag    <= en[EN_W-1] ? EN_W'(-en) : EN_W'(en);
    neg     <= (num[NUM_W-1] ^ en[EN_W-1]) && (num != '0);
    en_zero <= (en == '0);
    if (ctl.div_init) begin
      ovf  <= EN_W'(nmag >> QM_W) >= dmag;
      rem  <= EN_W'(nmag >> QM_W);
      nlo  <= nmag[QM_W-1:0];
      qm   <= '0;
      dcnt <= '0;
    end else if (ctl.div_step) begin
      if (trial >= {1'b0, dmag}) begin
        rem <= EN_W'(trial - {1'b0, dmag});
        qm  <= {qm[QM_W-2:0], 1'b1};
      end else begin
        rem <= EN_W'(trial);
        qm  <= {qm[QM_W-2:0], 1'b0};
      end
      nlo  <= nlo << 1;
      dcnt <= dcnt + 1'b1;
    end
  end

  // Floor correction, saturation and binning.
  logic [QV_W-1:0]        qmag;
  logic signed [QV_W-1:0] qv;
  logic                   under, over;
  logic signed [15:0]     pos_c;
  logic [15:0]            ubin;
  logic [BP_W-1:0]        bprod;
  logic [BIN_W-1:0]       bsel;

  assign qmag  = {2'b00, qm} + QV_W'(rem != '0);
  assign qv    = neg ? -$signed(qmag) : $signed({2'b00, qm});
  assign under = ovf ? neg : (qv < -19'sd32768);
  assign over  = ovf ? !neg : (qv > 19'sd32767);
  assign pos_c = under ? 16'sh8000 : (over ? 16'sh7FFF : qv[15:0]);
  assign ubin  = {~qv[15], qv[14:0]};
  assign bprod = BP_W'(ubin) * BP_W'(BINS);
  assign bsel  = bprod[16 +: BIN_W];

  sts_code_t          h_status;
  logic signed [15:0] h_pos;
  logic [BIN_W-1:0]   h_bin;
  logic [HIST_AW-1:0] cnt_addr;
  logic               counted;

  always_ff @(posedge clk) begin
    if (ctl.fin) begin
      counted  <= upf && !en_zero && !(under || over) || (upf && !en_zero);
      cnt_addr <= HIST_AW'(int'(chan) * BINS + int'(bsel));
      h_bin    <= '0;
      if (en_zero) begin
        h_status <= upf ? STS_ZERO : STS_SKIPPED;
        h_pos    <= '0;
      end else if (!upf) begin
        h_status <= STS_SKIPPED;
        h_pos    <= pos_c;
      end else if (under) begin
        h_status <= STS_UNDER;
        h_pos    <= pos_c;
      end else if (over) begin
        h_status <= STS_OVER;
        h_pos    <= pos_c;
      end else begin
        h_status <= STS_FILLED;
        h_pos    <= pos_c;
        h_bin    <= bsel;
      end
    end
  end

  // Histogram and out-of-range counters.
  logic [31:0]        hist_mem [HIST_DEPTH];
  logic [31:0]        under_mem [CHANNELS];
  logic [31:0]        over_mem [CHANNELS];
  logic [31:0]        hist_rd, under_rd, over_rd;
  logic [HIST_AW-1:0] hist_ra, clr_addr;
  logic               clr_low;

  assign hist_ra = ctl.bin_rd ? bin_addr : cnt_addr;
  assign clr_low = (clr_addr < HIST_AW'(CHANNELS));

  always_ff @(posedge clk) begin
    if (ctl.clr_step) begin
      hist_mem[clr_addr] <= '0;
    end else if (ctl.cnt_wr && h_status == STS_FILLED) begin
      hist_mem[cnt_addr] <= sat_inc(hist_rd);
    end
    hist_rd <= hist_mem[hist_ra];
  end

  always_ff @(posedge clk) begin
    if (ctl.clr_step && clr_low) begin
      under_mem[clr_addr[CH_W-1:0]] <= '0;
    end else if (ctl.cnt_wr && h_status == STS_UNDER) begin
      under_mem[chan] <= sat_inc(under_rd);
    end
    under_rd <= under_mem[chan];
  end

  always_ff @(posedge clk) begin
    if (ctl.clr_step && clr_low) begin
      over_mem[clr_addr[CH_W-1:0]] <= '0;
    end else if (ctl.cnt_wr && h_status == STS_OVER) begin
      over_mem[chan] <= sat_inc(over_rd);
    end
    over_rd <= over_mem[chan];
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clr_init) begin
      clr_addr <= '0;
    end else if (ctl.clr_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Result register.
  sts_code_t          res_status;
  logic signed [15:0] res_pos;
  logic [BIN_W-1:0]   res_bin;
  logic [31:0]        res_count;

  always_comb begin
    res_status = STS_SKIPPED;
    res_pos    = '0;
    res_bin    = '0;
    res_count  = '0;
    case (op)
      CMD_HIT: begin
        if (ok) begin
          res_status = h_status;
          res_pos    = h_pos;
          res_bin    = h_bin;
        end
      end
      CMD_PED, CMD_GAIN, CMD_SLOPE, CMD_ICPT, CMD_CLEAR: res_status = STS_WRITTEN;
      CMD_READ: begin
        res_status = STS_READ;
        if (ok) begin
          if (bidx < BINS) begin
            res_count = hist_rd;
          end else if (bidx == BINS) begin
            res_count = under_rd;
          end else if (bidx == BINS + 1) begin
            res_count = over_rd;
          end
        end
      end
      default: res_status = STS_SKIPPED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      status   <= res_status;
      position <= res_pos;
      bin      <= BIN_OUT_W'(res_bin);
      count    <= res_count;
    end
  end

  assign st.op       = op;
  assign st.ok       = ok;
  assign st.counted  = counted;
  assign st.div_last = (dcnt == DCNT_W'(QM_W - 1));
  assign st.clr_last = (clr_addr == HIST_AW'(HIST_DEPTH - 1));

endmodule

@@ src/strip_position_histogrammer_core.sv @@
// Position histogrammer for resistive-strip hits. A transaction is taken at a
// rising edge with start high and busy low; its single result appears on
// status, position, bin and count for exactly one cycle with done high, and
// the receiver cannot stall it. A hit on a valid channel spends most of its
// time in the divider, which produces one quotient bit per cycle for the 17
// quotient bits. Table writes, bin reads, unused commands and hits on a
// channel out of range go straight from decode to the result. After reset and
// after a clear command the histogram memory is swept one entry per cycle,
// all 196608 entries, while busy stays high. Busy drops in the same cycle that
// done is shown, so the next transaction may be accepted then.

module strip_position_histogrammer_core import sph_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           command,
  input  logic [3:0]           detector,
  input  logic [1:0]           strip,
  input  logic [1:0]           sector,
  input  logic                 side,
  input  logic                 upstream,
  input  logic [15:0]          left_adc,
  input  logic [15:0]          right_adc,
  input  logic signed [31:0]   table_value,
  input  logic [10:0]          bin_index,
  output logic                 done,
  output logic [2:0]           status,
  output logic signed [15:0]   position,
  output logic [BIN_OUT_W-1:0] bin,
  output logic [31:0]          count
);

  // The controller sequences the stages; the datapath holds the tables,
  // the arithmetic, the divider and the histogram memories.
  ctl_t  ctl;
  stat_t st;

  sph_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .ctl   (ctl),
    .busy  (busy)
  );

  sph_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .st          (st),
    .command     (command),
    .detector    (detector),
    .strip       (strip),
    .sector      (sector),
    .side        (side),
    .upstream    (upstream),
    .left_adc    (left_adc),
    .right_adc   (right_adc),
    .table_value (table_value),
    .bin_index   (bin_index),
    .done        (done),
    .status      (status),
    .position    (position),
    .bin         (bin),
    .count       (count)
  );

endmodule

@@ src/sph_checker.sv @@
`include "strip_position_histogrammer_core_defines.svh"

module sph_checker import sph_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 done,
  input logic [2:0]           status,
  input logic [BIN_OUT_W-1:0] bin,
  input logic [31:0]          count
);

  `SPH_ASSERT_ALWAYS(a_reset_sweep, rst |=> busy, "no clearing pass after reset")
  `SPH_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted transaction left block idle")
  `SPH_ASSERT(a_done_after_work, done |-> $past(busy), "result without a transaction")
  `SPH_ASSERT(a_count_on_read, (done && status != STS_READ) |-> (count == '0), "count outside read")
  `SPH_ASSERT(a_bin_on_fill, (done && status != STS_FILLED) |-> (bin == '0), "bin outside fill")

endmodule

bind strip_position_histogrammer_core sph_checker u_sph_checker (.*);

@@ tb/sv/strip_position_histogrammer_core_tb.sv @@
`timescale 1ns / 1ps

module strip_position_histogrammer_core_tb;
  import sph_pkg::*;

  // One command transaction as presented on the input ports.
  typedef struct {
    cmd_t        op;
    logic [3:0]  det;
    logic [1:0]  strp;
    logic [1:0]  sec;
    logic        sd;
    logic        up;
    logic [15:0] ladc;
    logic [15:0] radc;
    logic [31:0] tval;
    logic [10:0] bidx;
  } hit_cmd_t;

  // One result as expected on the output ports.
  typedef struct {
    sts_code_t          sts;
    logic signed [15:0] pos;
    logic [9:0]         bn;
    logic [31:0]        cnt;
  } hist_result_t;

  // Keeps its own copy of the calibration tables and the histogram state.
  // Every accepted transaction is folded into that state, and the result it
  // must produce is queued for comparison with the done strobes.
  class position_scoreboard;
    longint       ped_q4[PEDS];
    longint       gain_q14[CHANNELS];
    longint       slope_q16[CHANNELS];
    longint       icpt_q16[CHANNELS];
    // Sparse histogram keyed by channel*BINS + bin, with zero as default.
    int unsigned  hist_count[int];
    int unsigned  under_count[int];
    int unsigned  over_count[int];
    hist_result_t pending_results[$];
    int           recent_fills[$];
    int           errors;
    int           n_sts[8];

    function longint floor_quot(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && ((a < 0) != (b < 0))) q--;
      return q;
    endfunction

    function int unsigned bump(int unsigned v);
      return (v == 32'hFFFF_FFFF) ? v : v + 1;
    endfunction

    // Works out the result of one accepted transaction and updates state.
    function void note_command(hit_cmd_t c);
      hist_result_t r;
      logic   ok;
      int     ch, pr, key;
      longint r4, l4, rr, ll, e4, d4, en, q, qs, b;
      ok = c.det < DETECTORS && c.strp < STRIPS && c.sec < SECTORS;
      ch = ok ? (int'(c.det) * STRIPS + c.strp) * SECTORS + c.sec : 0;
      pr = ok ? (int'(c.det) * STRIPS + c.strp) * 2 : 0;
      r.sts = STS_SKIPPED;
      r.pos = '0;
      r.bn  = '0;
      r.cnt = '0;
      case (c.op)
        CMD_HIT: begin
          if (ok) begin
            r4 = longint'(c.radc & ADC_MASK) * 16 - ped_q4[pr];
            l4 = longint'(c.ladc & ADC_MASK) * 16 - ped_q4[pr + 1];
            rr = -(r4 * gain_q14[ch]);
            ll = l4 * 16384;
            // Round the Q.18 sum and difference to Q.4, ties upward.
            e4 = floor_quot(rr + ll + 8192, 16384);
            d4 = floor_quot(rr - ll + 8192, 16384);
            en = e4 * slope_q16[ch] + icpt_q16[ch] * 16;
            if (en == 0) begin
              r.sts = c.up ? STS_ZERO : STS_SKIPPED;
            end else begin
              q  = floor_quot(d4 * 64'sd2147483648, en);
              qs = q < -32768 ? -32768 : (q > 32767 ? 32767 : q);
              r.pos = qs[15:0];
              if (!c.up) begin
                r.sts = STS_SKIPPED;
              end else if (q < -32768) begin
                r.sts = STS_UNDER;
                under_count[ch] = bump(under_count.exists(ch) ? under_count[ch] : 0);
              end else if (q > 32767) begin
                r.sts = STS_OVER;
                over_count[ch] = bump(over_count.exists(ch) ? over_count[ch] : 0);
              end else begin
                b   = ((q + 32768) * BINS) >>> 16;
                key = ch * BINS + int'(b);
                r.sts = STS_FILLED;
                r.bn  = b[9:0];
                hist_count[key] = bump(hist_count.exists(key) ? hist_count[key] : 0);
                recent_fills.push_back(key);
                if (recent_fills.size() > 32) void'(recent_fills.pop_front());
              end
            end
          end
        end
        CMD_PED: begin
          if (ok) ped_q4[pr + c.sd] = longint'($signed(c.tval[19:0]));
          r.sts = STS_WRITTEN;
        end
        CMD_GAIN: begin
          if (ok) gain_q14[ch] = longint'(c.tval[15:0]);
          r.sts = STS_WRITTEN;
        end
        CMD_SLOPE: begin
          if (ok) slope_q16[ch] = longint'($signed(c.tval));
          r.sts = STS_WRITTEN;
        end
        CMD_ICPT: begin
          if (ok) icpt_q16[ch] = longint'($signed(c.tval));
          r.sts = STS_WRITTEN;
        end
        CMD_READ: begin
          r.sts = STS_READ;
          if (ok) begin
            key = ch * BINS + int'(c.bidx);
            if (c.bidx < BINS) r.cnt = hist_count.exists(key) ? hist_count[key] : 0;
            else if (c.bidx == BINS) r.cnt = under_count.exists(ch) ? under_count[ch] : 0;
            else if (c.bidx == BINS + 1) r.cnt = over_count.exists(ch) ? over_count[ch] : 0;
          end
        end
        CMD_CLEAR: begin
          hist_count.delete();
          under_count.delete();
          over_count.delete();
          recent_fills.delete();
          r.sts = STS_WRITTEN;
        end
        default: ;
      endcase
      n_sts[r.sts]++;
      pending_results.push_back(r);
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("MISMATCH at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(hist_result_t got);
      hist_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected done strobe, status", got.sts, -1);
      end else begin
        want = pending_results.pop_front();
        if (got.sts !== want.sts) report_mismatch("status", got.sts, want.sts);
        if (got.pos !== want.pos) report_mismatch("position", got.pos, want.pos);
        if (got.bn  !== want.bn)  report_mismatch("bin", got.bn, want.bn);
        if (got.cnt !== want.cnt) report_mismatch("count", got.cnt, want.cnt);
      end
    endtask
  endclass

  // The initial sweep and each clear walk the whole histogram memory, so a
  // quiet stretch as long as the histogram memory is deep is legitimate.
  localparam int STALL_LIMIT = 1000000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [2:0]         command = CMD_NOP;
  logic [3:0]         detector = '0;
  logic [1:0]         strip = '0;
  logic [1:0]         sector = '0;
  logic               side = 1'b0;
  logic               upstream = 1'b0;
  logic [15:0]        left_adc = '0;
  logic [15:0]        right_adc = '0;
  logic signed [31:0] table_value = '0;
  logic [10:0]        bin_index = '0;
  logic               busy;
  logic               done;
  logic [2:0]         status;
  logic signed [15:0] position;
  logic [BIN_OUT_W-1:0] bin;
  logic [31:0]        count;

  position_scoreboard sb = new();
  int                 idle_cycles = 0;
  int                 n_sent = 0;

  strip_position_histogrammer_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .detector(detector), .strip(strip), .sector(sector),
    .side(side), .upstream(upstream), .left_adc(left_adc), .right_adc(right_adc),
    .table_value(table_value), .bin_index(bin_index),
    .done(done), .status(status), .position(position), .bin(bin), .count(count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Results cannot be held off, so every done cycle is checked at its edge.
  always @(posedge clk) begin
    hist_result_t got;
    if (!rst && done) begin
      got.sts = sts_code_t'(status);
      got.pos = position;
      got.bn  = bin;
      got.cnt = count;
      sb.check_result(got);
    end
  end

  // Watchdog: counts edges at which neither side of the block moves.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Presents one transaction and holds it until the block takes it. Start is
  // left high; the caller lowers it only if a gap follows.
  task send_command(hit_cmd_t c);
    start       <= 1'b1;
    command     <= c.op;
    detector    <= c.det;
    strip       <= c.strp;
    sector      <= c.sec;
    side        <= c.sd;
    upstream    <= c.up;
    left_adc    <= c.ladc;
    right_adc   <= c.radc;
    table_value <= c.tval;
    bin_index   <= c.bidx;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(c);
    n_sent++;
  endtask

  task send_with_gap(hit_cmd_t c, int gap);
    send_command(c);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task drain_results();
    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  function hit_cmd_t blank_command(cmd_t op, int ch);
    hit_cmd_t c;
    c.op   = op;
    c.det  = ch / (STRIPS * SECTORS);
    c.strp = (ch / SECTORS) % STRIPS;
    c.sec  = ch % SECTORS;
    c.sd   = $urandom_range(0, 1);
    c.up   = $urandom_range(0, 1);
    c.ladc = $urandom;
    c.radc = $urandom;
    c.tval = $urandom;
    c.bidx = $urandom_range(0, 2047);
    return c;
  endfunction

  // Calibration values that mostly keep positions near [-1,1), with an
  // occasional full-range word.
  function logic [31:0] calib_word(cmd_t op);
    logic [31:0] w;
    w = $urandom;
    if ($urandom_range(0, 9) == 0) return w;
    case (op)
      CMD_PED:   return {w[31:20], 20'(int'($urandom_range(0, 4000)) - 1000)};
      CMD_GAIN:  return {w[31:16], 16'($urandom_range(12000, 21000))};
      CMD_SLOPE: return ($urandom_range(0, 1) ? 32'sd1 : -32'sd1)
                        * int'($urandom_range(40000, 90000));
      default:   return int'($urandom_range(0, 200000)) - 100000;
    endcase
  endfunction

  function hit_cmd_t random_command();
    hit_cmd_t c;
    int       pick, key;
    pick = $urandom_range(0, 99);
    c = blank_command(CMD_HIT, $urandom_range(0, CHANNELS - 1));
    if (pick < 62) begin
      c.up = ($urandom_range(0, 7) != 0);
      // Keep the two ends comparable most of the time so that positions land
      // inside the histogram range.
      if ($urandom_range(0, 3) != 0) begin
        c.ladc = $urandom_range(0, 60000);
        c.radc = c.ladc / 2 + $urandom_range(0, 20000);
      end
    end else if (pick < 74) begin
      c.op   = cmd_t'($urandom_range(CMD_PED, CMD_ICPT));
      c.tval = calib_word(c.op);
    end else if (pick < 90) begin
      c.op = CMD_READ;
      if (sb.recent_fills.size() != 0 && $urandom_range(0, 2) != 0) begin
        key = sb.recent_fills[$urandom_range(0, sb.recent_fills.size() - 1)];
        c = blank_command(CMD_READ, key / BINS);
        c.bidx = key % BINS;
      end else if ($urandom_range(0, 1)) begin
        c.bidx = BINS + $urandom_range(0, 1);
      end
    end else if (pick < 96) begin
      // Channel beyond the last detector: every operation is harmless.
      c.op  = cmd_t'($urandom_range(CMD_HIT, CMD_READ));
      c.det = $urandom_range(DETECTORS, 15);
    end else begin
      c.op = CMD_NOP;
    end
    return c;
  endfunction

  initial begin
    hit_cmd_t c;
    int       n_random;
    // Table loading and the directed cases already take about 700
    // transactions, so the random phase tops the run up to about 900.
    n_random = 200;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Load every calibration entry so no hit ever reads an unwritten one.
    for (int ch = 0; ch < CHANNELS; ch++) begin
      for (int op = CMD_GAIN; op <= CMD_ICPT; op++) begin
        c = blank_command(cmd_t'(op), ch);
        c.tval = calib_word(cmd_t'(op));
        send_with_gap(c, (ch % 8 == 0) ? $urandom_range(0, 3) : 0);
      end
      if (ch % SECTORS == 0) begin
        for (int s = 0; s < 2; s++) begin
          c = blank_command(CMD_PED, ch);
          c.sd = s;
          c.tval = calib_word(CMD_PED);
          send_with_gap(c, 0);
        end
      end
    end

    // Directed: unity calibration on channel 1, then extremes and corners.
    c = blank_command(CMD_SLOPE, 1); c.tval = 32'sd65536; send_with_gap(c, 0);
    c = blank_command(CMD_ICPT, 1);  c.tval = 0;          send_with_gap(c, 0);
    c = blank_command(CMD_GAIN, 1);  c.tval = 16384;      send_with_gap(c, 0);
    c = blank_command(CMD_HIT, 1); c.up = 1; c.ladc = 16'hFFFF; c.radc = 16'hFFFF;
    send_with_gap(c, 1);
    c = blank_command(CMD_HIT, 1); c.up = 1; c.ladc = 0; c.radc = 0; send_with_gap(c, 0);
    c = blank_command(CMD_HIT, 1); c.up = 1; c.ladc = 1000; c.radc = 3000;
    send_with_gap(c, 0);
    c = blank_command(CMD_HIT, 1); c.up = 0; c.ladc = 1000; c.radc = 3000;
    send_with_gap(c, 2);
    // Zero energy: slope and intercept both zero.
    c = blank_command(CMD_SLOPE, 2); c.tval = 0; send_with_gap(c, 0);
    c = blank_command(CMD_ICPT, 2);  c.tval = 0; send_with_gap(c, 0);
    c = blank_command(CMD_HIT, 2); c.up = 1; send_with_gap(c, 0);
    c = blank_command(CMD_HIT, 2); c.up = 0; send_with_gap(c, 3);
    // Reads of a bin, the underflow and overflow counters, and a bad index.
    c = blank_command(CMD_READ, 1); c.bidx = BINS;     send_with_gap(c, 0);
    c = blank_command(CMD_READ, 1); c.bidx = BINS + 1; send_with_gap(c, 0);
    c = blank_command(CMD_READ, 1); c.bidx = 2047;     send_with_gap(c, 0);
    c = blank_command(CMD_READ, 1); c.bidx = 0;        send_with_gap(c, 0);
    // Out-of-range detector for a hit, a write and a read.
    c = blank_command(CMD_HIT, 0);  c.det = 15; c.up = 1; send_with_gap(c, 0);
    c = blank_command(CMD_PED, 0);  c.det = 12; send_with_gap(c, 0);
    c = blank_command(CMD_READ, 0); c.det = 13; c.bidx = 5; send_with_gap(c, 0);
    c = blank_command(CMD_NOP, 5); send_with_gap(c, 0);
    c = blank_command(CMD_CLEAR, 5); send_with_gap(c, 0);
    c = blank_command(CMD_READ, 1); c.bidx = BINS + 1; send_with_gap(c, 0);

    // Random traffic with one mid-run clear and one pause until quiet.
    for (int i = 0; i < n_random; i++) begin
      if (i == n_random / 3) drain_results();
      c = (i == n_random / 2) ? blank_command(CMD_CLEAR, 0) : random_command();
      send_with_gap(c, (i % 200 < 40) ? 0 : $urandom_range(0, 3));
    end

    drain_results();
    repeat (40) @(posedge clk);
    $display("Sent %0d transactions: %0d filled, %0d skipped, %0d under, %0d over,",
             n_sent, sb.n_sts[STS_FILLED], sb.n_sts[STS_SKIPPED],
             sb.n_sts[STS_UNDER], sb.n_sts[STS_OVER]);
    $display("  %0d zero energy, %0d writes or clears, %0d reads.",
             sb.n_sts[STS_ZERO], sb.n_sts[STS_WRITTEN], sb.n_sts[STS_READ]);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
